FILE: rtl/mur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mur_pkg;

    localparam logic [63:0] MUR_M      = 64'hc6a4a7935bd1e995;
    localparam int          MUR_R      = 47;
    localparam logic [31:0] SEED_RESET = 32'd19820125;

    // Depth of the queue between the front and the back; a power of two.
    localparam int QDEPTH  = 2;
    localparam int QADDR_W = $clog2(QDEPTH);

    // Word classes assigned by the front.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_PART = 2'd2;

    typedef struct packed {
        logic [63:0] data;
        logic [1:0]  kind;
        logic [30:0] len;
        logic        first;
        logic        last;
    } work_t;

endpackage

`default_nettype wire

FILE: rtl/murmur64a_string_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Word
// input     in         push / full               data_word, byte_count, message_length,
//                                                last_word
// result    out        empty / pop               hash_value
// seed      in         hash_seed_write           hash_seed
//
// A full 8-byte word chains three 64-bit products by M, a partial word one and
// an empty word none; the first word of a message adds one more and the last
// adds one more, and its hash then waits until the result register has room.
// All of them come from the single 32x32 multiplier, which builds each 64-bit
// product by M from three 32x32 partial products.
// Reset empties the word queue and the result register, idles the sequencer
// and restores the seed to its default value.
// Two words can wait in the input queue, and a finished hash is held in the
// result register while the next message is already being processed.

module murmur64a_string_hash
    import mur_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic [30:0] message_length,
    input  wire logic        last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      hash_value,
    input  wire logic        hash_seed_write,
    input  wire logic [31:0] hash_seed
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        q_full;
    logic        q_push;
    work_t       q_wr_item;
    logic        q_empty;
    logic        q_pop;
    work_t       q_rd_item;
    logic        mul_start;
    logic [63:0] mul_operand;
    logic        mul_done;
    logic [63:0] mul_product;
    logic        out_valid;

    assign seed_next = hash_seed_write ? hash_seed : seed_reg;
    assign empty     = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mur_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .message_length (message_length),
        .last_word      (last_word),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_wr_item)
    );

    mur_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    mur_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    mur_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .q_empty     (q_empty),
        .q_item      (q_rd_item),
        .q_pop       (q_pop),
        .mul_start   (mul_start),
        .mul_operand (mul_operand),
        .mul_done    (mul_done),
        .mul_product (mul_product),
        .out_pop     (pop),
        .out_valid   (out_valid),
        .out_hash    (hash_value)
    );

endmodule

`default_nettype wire

FILE: rtl/mur_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mur_front
    import mur_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic [30:0] message_length,
    input  wire logic        last_word,
    input  wire logic        q_full,
    output logic             q_push,
    output work_t            q_item
);

    logic in_msg_reg;
    logic in_msg_next;
    logic [63:0] masked;

    assign full   = q_full;
    assign q_push = push && !q_full;

    // Bytes past the count are cleared so the back can xor the word as is.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked[8*i +: 8] = (byte_count > 4'(i)) ? data_word[8*i +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        q_item.data  = masked;
        q_item.len   = message_length;
        q_item.first = !in_msg_reg;
        q_item.last  = last_word;
        if (byte_count == 4'd0)
        begin
            q_item.kind = KIND_NONE;
        end
        else if (byte_count inside {[4'd1:4'd7]})
        begin
            q_item.kind = KIND_PART;
        end
        else
        begin
            q_item.kind = KIND_FULL;
        end
    end

    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (q_push)
        begin
            in_msg_next = !last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mur_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mur_queue
    import mur_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t wr_item,
    output logic       full,
    input  wire logic  pop,
    output work_t      rd_item,
    output logic       empty
);

    work_t               mem_reg [QDEPTH];
    logic [QADDR_W-1:0]  wr_ptr_reg;
    logic [QADDR_W-1:0]  wr_ptr_next;
    logic [QADDR_W-1:0]  rd_ptr_reg;
    logic [QADDR_W-1:0]  rd_ptr_next;
    logic [QADDR_W:0]    count_reg;
    logic [QADDR_W:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QADDR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mur_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module mur_mul
    import mur_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic             done,
    output logic [63:0]      product
);

    // Low 64 bits of operand * M from three 32x32 partial products,
    // one multiplier pass per cycle and an accumulate on the next.
    localparam logic [1:0] PH_LOLO = 2'd0;
    localparam logic [1:0] PH_LOHI = 2'd1;
    localparam logic [1:0] PH_HILO = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    logic        active_reg;
    logic        active_next;
    logic [1:0]  ph_reg;
    logic [1:0]  ph_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] x_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign done    = done_reg;
    assign product = acc_reg;

    assign mul_a = (ph_reg == PH_HILO) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (ph_reg == PH_LOHI) ? MUR_M[63:32] : MUR_M[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        active_next = active_reg;
        ph_next     = ph_reg;
        done_next   = 1'b0;
        prod_next   = mul_p;
        acc_next    = acc_reg;
        if (!active_reg)
        begin
            if (start)
            begin
                active_next = 1'b1;
                ph_next     = PH_LOLO;
            end
        end
        else
        begin
            ph_next = ph_reg + 1'b1;
            case (ph_reg)
                PH_LOLO:
                begin
                    acc_next = acc_reg;
                end
                PH_LOHI:
                begin
                    acc_next = prod_reg;
                end
                PH_HILO:
                begin
                    acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                end
                PH_LAST:
                begin
                    acc_next    = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ph_reg     <= PH_LOLO;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ph_reg     <= ph_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!active_reg && start)
        begin
            x_reg <= operand;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

FILE: rtl/mur_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mur_back
    import mur_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] seed,
    input  wire logic        q_empty,
    input  wire work_t       q_item,
    output logic             q_pop,
    output logic             mul_start,
    output logic [63:0]      mul_operand,
    input  wire logic        mul_done,
    input  wire logic [63:0] mul_product,
    input  wire logic        out_pop,
    output logic             out_valid,
    output logic [63:0]      out_hash
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_WORD = 4'd2;
    localparam logic [3:0] S_K1   = 4'd3;
    localparam logic [3:0] S_K2   = 4'd4;
    localparam logic [3:0] S_H    = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    work_t       cur_reg;
    work_t       cur_next;
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_hash_reg;
    logic [63:0] out_hash_next;
    logic        out_free;

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_free  = !out_valid_reg || out_pop;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        h_next         = h_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_hash_next  = out_hash_reg;
        q_pop          = 1'b0;
        mul_start      = 1'b0;
        mul_operand    = h_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.first)
                    begin
                        mul_start   = 1'b1;
                        mul_operand = {33'd0, q_item.len};
                        state_next  = S_INIT;
                    end
                    else
                    begin
                        state_next = S_WORD;
                    end
                end
            end
            S_INIT:
            begin
                if (mul_done)
                begin
                    h_next     = {32'd0, seed} ^ mul_product;
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                case (cur_reg.kind)
                    KIND_FULL:
                    begin
                        mul_start   = 1'b1;
                        mul_operand = cur_reg.data;
                        state_next  = S_K1;
                    end
                    KIND_PART:
                    begin
                        mul_start   = 1'b1;
                        mul_operand = h_reg ^ cur_reg.data;
                        state_next  = S_H;
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end
            S_K1:
            begin
                if (mul_done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = mul_product ^ (mul_product >> MUR_R);
                    state_next  = S_K2;
                end
            end
            S_K2:
            begin
                if (mul_done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = h_reg ^ mul_product;
                    state_next  = S_H;
                end
            end
            S_H:
            begin
                if (mul_done)
                begin
                    h_next     = mul_product;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (cur_reg.last)
                begin
                    mul_start   = 1'b1;
                    mul_operand = h_reg ^ (h_reg >> MUR_R);
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (mul_done)
                begin
                    h_next     = mul_product ^ (mul_product >> MUR_R);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait here until the result register has room.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = h_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        h_reg        <= h_next;
        out_hash_reg <= out_hash_next;
    end

endmodule

`default_nettype wire
